/* hw/rtl/reversible_deque_macros.svh */
// assertion macros for the reversible deque
// expects clk_i and rst_ni in the scope of use
`ifndef REVERSIBLE_DEQUE_MACROS_SVH
`define REVERSIBLE_DEQUE_MACROS_SVH

// same-cycle implication
`define RD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rd_pkg.sv */
// shared types and constants for the reversible deque
// no dependencies
`default_nettype none

package rd_pkg;

  localparam int unsigned DepthDefault     = 1024;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned FuncWidth        = 3;
  localparam int unsigned ValueWidth       = 32;
  localparam int unsigned StatusWidth      = 2;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_POP_BACK   = 3'd0,
    FUNC_POP_FRONT  = 3'd1,
    FUNC_REVERSE    = 3'd2,
    FUNC_PUSH_BACK  = 3'd3,
    FUNC_PUSH_FRONT = 3'd4
  } func_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

/* hw/rtl/reversible_deque.sv */
// reversible deque top level: pointers, direction flag and result register
// depends on rd_pkg, rd_ram and reversible_deque_macros.svh
`default_nettype none

// Bounded double-ended queue of signed values held in one single-port RAM
// with a registered read. A push, a reverse, a pop on an empty queue and a
// push into a full queue do not read the RAM and do not stall the input, so
// such items can be transferred back to back while no result is held back.
// A successful pop reads the RAM: its data passes the RAM read register
// before the result register, and the input is stalled while the read is
// pending. While a result waits under the result stall the input is stalled
// as well; a result that leaves in a cycle frees the register for the item
// transferred in that cycle. No clearing pass is needed after reset.

module reversible_deque #(
  parameter int unsigned DEPTH      = rd_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = rd_pkg::DataWidthDefault
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [rd_pkg::FuncWidth-1:0]           func_i,
  input  wire logic signed [rd_pkg::ValueWidth-1:0]   value_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [rd_pkg::ValueWidth-1:0]        popped_value_o,
  output logic [rd_pkg::StatusWidth-1:0]              status_o
);

  import rd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  rev_q, rev_d;
  logic                  pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] out_data_q, out_data_d;
  status_e               out_status_q, out_status_d;

  logic                  in_xfer;
  logic                  phys_back;
  logic                  is_empty, is_full;
  logic [AW-1:0]         head_inc, head_dec, tail_last, tail_next;
  logic [SW-1:0]         sum_last, sum_next;
  logic                  ram_en, ram_we;
  logic [AW-1:0]         ram_addr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic signed [63:0]    rd_ext;
  func_e                 func;

  rd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign func       = func_e'(func_i);
  assign in_stall_o = pend_q | (out_valid_q & out_stall_i);
  assign in_xfer    = in_valid_i & ~in_stall_o;

  assign is_empty  = (count_q == '0);
  assign is_full   = (count_q == CW'(DEPTH));
  assign phys_back = ((func == FUNC_POP_BACK) || (func == FUNC_PUSH_BACK)) ^ rev_q;

  assign head_inc  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign head_dec  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);
  assign sum_last  = SW'(head_q) + SW'(count_q) - SW'(1);
  assign sum_next  = SW'(head_q) + SW'(count_q);
  assign tail_last = (sum_last >= SW'(DEPTH)) ? AW'(sum_last - SW'(DEPTH)) : AW'(sum_last);
  assign tail_next = (sum_next >= SW'(DEPTH)) ? AW'(sum_next - SW'(DEPTH)) : AW'(sum_next);

  assign rd_ext    = 64'($signed(ram_rdata));
  assign ram_wdata = DATA_WIDTH'($unsigned(value_i));

  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    rev_d        = rev_q;
    pend_d       = 1'b0;
    ram_en       = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = head_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_data_d   = out_data_q;
    out_status_d = out_status_q;

    // read data of a pop arrives
    if (pend_q) begin
      out_valid_d  = 1'b1;
      out_data_d   = rd_ext[ValueWidth-1:0];
      out_status_d = STATUS_OK;
    end

    if (in_xfer) begin
      case (func)
        FUNC_POP_BACK, FUNC_POP_FRONT: begin
          if (is_empty) begin
            out_valid_d  = 1'b1;
            out_data_d   = '0;
            out_status_d = STATUS_EMPTY;
          end else begin
            ram_en  = 1'b1;
            pend_d  = 1'b1;
            count_d = count_q - CW'(1);
            if (phys_back) begin
              ram_addr = tail_last;
            end else begin
              ram_addr = head_q;
              head_d   = head_inc;
            end
          end
        end
        FUNC_REVERSE: begin
          if (!is_empty) begin
            rev_d = ~rev_q;
          end
        end
        FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
          if (is_full) begin
            out_valid_d  = 1'b1;
            out_data_d   = '0;
            out_status_d = STATUS_FULL;
          end else begin
            ram_en  = 1'b1;
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
            if (phys_back) begin
              ram_addr = tail_next;
            end else begin
              ram_addr = head_dec;
              head_d   = head_dec;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_data_q;
  assign status_o       = out_status_q;

`include "reversible_deque_macros.svh"

  `RD_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
  `RD_ASSERT_IMPL(a_no_xfer_in_read, pend_q, !in_xfer, "transfer during pending read")
  `RD_ASSERT_NEXT(a_read_result, pend_q, out_valid_q && out_status_q == STATUS_OK,
                  "pop read gave no result")
  `RD_ASSERT_NEXT(a_empty_pop,
                  in_xfer && is_empty && (func_i == FUNC_POP_BACK || func_i == FUNC_POP_FRONT),
                  out_valid_q && out_status_q == STATUS_EMPTY, "empty pop not reported")

endmodule

`default_nettype wire

/* hw/rtl/rd_ram.sv */
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module rd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

/* tb/reversible_deque_checker.sv */
// reversible deque checker: mirrors the queue contents, pointers and direction
// and compares every result transfer; depends on rd_pkg
`default_nettype none

module reversible_deque_checker #(
  parameter int unsigned DEPTH      = rd_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = rd_pkg::DataWidthDefault
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  input  wire logic                                 in_stall_i,
  input  wire logic [rd_pkg::FuncWidth-1:0]         func_i,
  input  wire logic [rd_pkg::ValueWidth-1:0]        value_i,
  input  wire logic                                 out_valid_i,
  input  wire logic                                 out_stall_i,
  input  wire logic signed [rd_pkg::ValueWidth-1:0] popped_value_i,
  input  wire logic [rd_pkg::StatusWidth-1:0]       status_i,
  output int                                        mismatch_count_o,
  output int                                        awaited_o
);

  import rd_pkg::*;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    status_e                      status;
  } pop_result_t;

  pop_result_t             awaited_results[$];
  pop_result_t             oldest;
  logic [DATA_WIDTH-1:0]   deque_entries[DEPTH];
  int unsigned             front_idx;
  int unsigned             occupancy;
  logic                    flipped;
  int                      mismatches = 0;
  int                      awaited_n  = 0;

  assign mismatch_count_o = mismatches;
  assign awaited_o        = awaited_n;

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) begin
      $display("%0t mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic logic signed [ValueWidth-1:0] sign_extend_entry(
    input logic [DATA_WIDTH-1:0] raw
  );
    logic signed [DATA_WIDTH-1:0] narrow;
    logic signed [63:0]           wide;
    narrow = raw;
    wide   = narrow;
    return wide[ValueWidth-1:0];
  endfunction

  task automatic expect_result(input pop_result_t res);
    awaited_results = {awaited_results, res};
  endtask

  task automatic apply_op(input logic [FuncWidth-1:0] code,
                          input logic [ValueWidth-1:0] operand);
    logic        far_end;
    int unsigned spot;
    pop_result_t res;
    far_end = ((code == FUNC_POP_BACK) || (code == FUNC_PUSH_BACK)) != flipped;
    case (code)
      FUNC_REVERSE: begin
        if (occupancy != 0) flipped = !flipped;
      end
      FUNC_POP_BACK, FUNC_POP_FRONT: begin
        if (occupancy == 0) begin
          res.value  = '0;
          res.status = STATUS_EMPTY;
        end else begin
          if (far_end) begin
            spot = (front_idx + occupancy - 1) % DEPTH;
          end else begin
            spot      = front_idx;
            front_idx = (front_idx + 1) % DEPTH;
          end
          res.value  = sign_extend_entry(deque_entries[spot]);
          res.status = STATUS_OK;
          occupancy--;
        end
        expect_result(res);
      end
      FUNC_PUSH_BACK, FUNC_PUSH_FRONT: begin
        if (occupancy >= DEPTH) begin
          res.value  = '0;
          res.status = STATUS_FULL;
          expect_result(res);
        end else if (far_end) begin
          occupancy++;
          deque_entries[(front_idx + occupancy - 1) % DEPTH] = DATA_WIDTH'(operand);
        end else begin
          front_idx                = (front_idx + DEPTH - 1) % DEPTH;
          deque_entries[front_idx] = DATA_WIDTH'(operand);
          occupancy++;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_results.delete();
      front_idx = 0;
      occupancy = 0;
      flipped   = 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing awaited: value %0d status %0d",
                                    popped_value_i, status_i));
        end else begin
          oldest = awaited_results[0];
          awaited_results.delete(0);
          if (popped_value_i !== oldest.value) begin
            report_mismatch($sformatf("popped value %0d, expected %0d",
                                      popped_value_i, oldest.value));
          end
          if (status_i !== oldest.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", status_i, oldest.status));
          end
        end
      end
      if (in_valid_i && !in_stall_i) apply_op(func_i, value_i);
    end
    awaited_n <= awaited_results.size();
  end

endmodule

`default_nettype wire

/* tb/reversible_deque_tb.sv */
// reversible deque testbench top: clock, reset, operation stimulus and verdict
// depends on rd_pkg, reversible_deque and reversible_deque_checker
`default_nettype none

module reversible_deque_tb;

  import rd_pkg::*;

  localparam int unsigned     Depth          = DepthDefault;
  localparam int unsigned     RandomOps      = 1750;
  localparam logic [2:0]      FuncSpareFirst = 3'd5;
  localparam logic [2:0]      FuncSpareLast  = 3'd7;

  typedef enum {MIX, FILL, BRIM, DRAIN} stage_e;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [FuncWidth-1:0]          func;
  logic signed [ValueWidth-1:0]  value;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [ValueWidth-1:0]  popped_value;
  logic [StatusWidth-1:0]        status;
  int                            mismatches;
  int                            awaited;
  bit                            no_gaps;
  int unsigned                   level;

  reversible_deque dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .popped_value_o (popped_value),
    .status_o       (status)
  );

  reversible_deque_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .func_i           (func),
    .value_i          (value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .popped_value_i   (popped_value),
    .status_i         (status),
    .mismatch_count_o (mismatches),
    .awaited_o        (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side back-pressure
  initial begin : sink_pacing
    bit          stalling;
    int unsigned span;
    int unsigned roll;
    out_stall = 1'b0;
    stalling  = 1'b0;
    span      = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        stalling = !stalling;
        roll     = $urandom_range(0, 99);
        if (stalling) begin
          if (roll < 70) span = $urandom_range(1, 2);
          else if (roll < 95) span = $urandom_range(3, 8);
          else span = $urandom_range(15, 40);
        end else begin
          if (roll < 80) span = $urandom_range(1, 6);
          else span = $urandom_range(30, 150);
        end
      end
      span--;
      out_stall <= stalling;
    end
  end

  task automatic issue(input logic [FuncWidth-1:0] code, input logic [ValueWidth-1:0] operand);
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 55) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= code;
    value    <= operand;
    do @(posedge clk); while (in_stall);
    if ((code == FUNC_PUSH_BACK || code == FUNC_PUSH_FRONT) && level < Depth) begin
      level++;
    end else if ((code == FUNC_POP_BACK || code == FUNC_POP_FRONT) && level > 0) begin
      level--;
    end
  endtask

  function automatic logic [FuncWidth-1:0] pick_code(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return FuncWidth'($urandom_range(FuncSpareFirst, FuncSpareLast));
    if (roll < 8) return FUNC_REVERSE;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? FUNC_PUSH_BACK : FUNC_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? FUNC_POP_BACK : FUNC_POP_FRONT;
  endfunction

  initial begin : stimulus
    stage_e                  stage;
    int unsigned             counted;
    int unsigned             brim_items;
    int unsigned             push_pct;
    logic [FuncWidth-1:0]    code;
    logic [ValueWidth-1:0]   operand;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    func     = '0;
    value    = '0;
    no_gaps  = 1'b0;
    level    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue corners, extremes, spare codes
    issue(FUNC_POP_BACK, 32'h0);
    issue(FUNC_POP_FRONT, 32'hffff_ffff);
    issue(FUNC_REVERSE, 32'h0);
    issue(FUNC_PUSH_BACK, 32'h7fff_ffff);
    issue(FUNC_PUSH_FRONT, 32'h8000_0000);
    issue(FUNC_PUSH_BACK, 32'h0);
    issue(FUNC_PUSH_FRONT, 32'hffff_ffff);
    for (int c = FuncSpareFirst; c <= FuncSpareLast; c++) begin
      issue(FuncWidth'(c), $urandom());
    end
    issue(FUNC_POP_FRONT, 32'h0);
    issue(FUNC_REVERSE, 32'h0);
    issue(FUNC_POP_FRONT, 32'h0);
    issue(FUNC_PUSH_BACK, 32'h1);
    issue(FUNC_POP_BACK, 32'h0);
    issue(FUNC_POP_BACK, 32'h0);
    issue(FUNC_POP_FRONT, 32'h0);
    issue(FUNC_POP_BACK, 32'h0);
    issue(FUNC_PUSH_FRONT, 32'h5555_5555);
    issue(FUNC_PUSH_BACK, 32'haaaa_aaaa);
    issue(FUNC_REVERSE, 32'h0);
    issue(FUNC_POP_BACK, 32'h0);
    issue(FUNC_POP_FRONT, 32'h0);
    issue(FUNC_REVERSE, 32'h0);
    issue(FUNC_PUSH_FRONT, 32'h1234_5678);

    // random part: mix near empty, fill to full, hover at full, then drain
    stage      = MIX;
    counted    = 0;
    brim_items = 0;
    while (counted < RandomOps) begin
      no_gaps = (counted % 160) < 40;
      if (stage == MIX && counted >= 200) stage = FILL;
      if (stage == FILL && level == Depth) stage = BRIM;
      if (stage == BRIM && brim_items >= 150) stage = DRAIN;
      case (stage)
        MIX:     push_pct = 50;
        FILL:    push_pct = 98;
        BRIM:    push_pct = 60;
        default: push_pct = 15;
      endcase
      code = pick_code(push_pct);
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       operand = 32'h7fff_ffff;
            1:       operand = 32'h8000_0000;
            2:       operand = 32'h0;
            default: operand = 32'hffff_ffff;
          endcase
        end
        default: operand = $urandom();
      endcase
      issue(code, operand);
      if (code <= FUNC_PUSH_FRONT) begin
        counted++;
        if (stage == BRIM) brim_items++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
